// File: design/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and the digit-to-character mapping of the radix
// digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int RADIX_WIDTH    = 6;
    localparam int REM_WIDTH      = 6;
    localparam int CHAR_WIDTH     = 7;

    // Quotient bits resolved per clock by the divider.
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int DIV_WIDTH      = DIV_CYCLES * BITS_PER_CYCLE;
    localparam int CYC_WIDTH      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Radix two gives the longest run: one digit per value bit.
    localparam int MAX_DIGITS     = VALUE_WIDTH;
    localparam int COUNT_WIDTH    = $clog2(MAX_DIGITS + 1);

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN      = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX      = RADIX_WIDTH'(36);
    localparam logic [REM_WIDTH-1:0]   DECIMAL_DIGITS = REM_WIDTH'(10);
    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO     = CHAR_WIDTH'(8'h30);
    localparam logic [CHAR_WIDTH-1:0]  ASCII_UPPER_A  = CHAR_WIDTH'(8'h41);
    localparam logic [CHAR_WIDTH-1:0]  ASCII_NINE     = CHAR_WIDTH'(8'h39);
    localparam logic [CHAR_WIDTH-1:0]  ASCII_UPPER_Z  = CHAR_WIDTH'(8'h5A);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_PUSH,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic pop;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quo_zero;
        logic last_digit;
    } t_status;

    // Digits 0-9 map to '0'-'9' and digits 10-35 map to 'A'-'Z'.
    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(
        input logic [REM_WIDTH-1:0] digit
    );
        logic [CHAR_WIDTH-1:0] wide;
        wide = CHAR_WIDTH'(digit);
        if (digit < DECIMAL_DIGITS) begin
            return ASCII_ZERO + wide;
        end
        return ASCII_UPPER_A + (wide - CHAR_WIDTH'(DECIMAL_DIGITS));
    endfunction

endpackage

`default_nettype wire

// File: design/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Multi-bit-per-cycle restoring divider, digit stack and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rdc_pkg::t_cmd                     i_cmd,
    input  wire logic [rdc_pkg::VALUE_WIDTH-1:0]   i_value,
    input  wire logic [rdc_pkg::RADIX_WIDTH-1:0]   i_radix,
    output rdc_pkg::t_status                       o_status,
    output logic                                   o_strobe,
    output logic [rdc_pkg::CHAR_WIDTH-1:0]         o_digit_char,
    output logic                                   o_last
);

    logic [rdc_pkg::DIV_WIDTH-1:0]   r_quo;
    logic [rdc_pkg::DIV_WIDTH-1:0]   n_quo;
    logic [rdc_pkg::REM_WIDTH-1:0]   r_rem;
    logic [rdc_pkg::REM_WIDTH-1:0]   n_rem;
    logic [rdc_pkg::RADIX_WIDTH-1:0] r_radix;
    logic [rdc_pkg::RADIX_WIDTH-1:0] sat_radix;
    logic [rdc_pkg::REM_WIDTH-1:0]   r_stack [rdc_pkg::MAX_DIGITS];
    logic [rdc_pkg::COUNT_WIDTH-1:0] r_count;
    logic                            r_strobe;
    logic [rdc_pkg::CHAR_WIDTH-1:0]  r_char;
    logic                            r_last;

    // Out-of-range radix values are clamped to the nearest legal base.
    always_comb begin
        if (i_radix < rdc_pkg::RADIX_MIN) begin
            sat_radix = rdc_pkg::RADIX_MIN;
        end else if (i_radix > rdc_pkg::RADIX_MAX) begin
            sat_radix = rdc_pkg::RADIX_MAX;
        end else begin
            sat_radix = i_radix;
        end
    end

    // Resolve BITS_PER_CYCLE quotient bits, most significant first.
    always_comb begin
        logic [rdc_pkg::REM_WIDTH:0] rem_wide;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < rdc_pkg::BITS_PER_CYCLE; i++) begin
            rem_wide = {n_rem, n_quo[rdc_pkg::DIV_WIDTH-1]};
            n_quo    = {n_quo[rdc_pkg::DIV_WIDTH-2:0], 1'b0};
            if (rem_wide >= {1'b0, r_radix}) begin
                rem_wide = rem_wide - {1'b0, r_radix};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_wide[rdc_pkg::REM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= rdc_pkg::DIV_WIDTH'(i_value);
            r_rem   <= '0;
            r_radix <= sat_radix;
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end else if (i_cmd.push) begin
            r_rem <= '0;
        end
    end

    // Digit stack: entry zero always holds the most recent digit, which is
    // the most significant one still to be emitted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[0] <= r_rem;
            for (int i = 1; i < rdc_pkg::MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < rdc_pkg::MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + rdc_pkg::COUNT_WIDTH'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - rdc_pkg::COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_char <= rdc_pkg::digit_to_ascii(r_stack[0]);
            r_last <= (r_count == rdc_pkg::COUNT_WIDTH'(1));
        end
    end

    assign o_status.quo_zero   = (r_quo == '0);
    assign o_status.last_digit = (r_count == rdc_pkg::COUNT_WIDTH'(1));
    assign o_strobe            = r_strobe;
    assign o_digit_char        = r_char;
    assign o_last              = r_last;

endmodule

`default_nettype wire

// File: design/rdc_controller.sv
// ----------------------------------------------------------------------------
// rdc_controller
// Sequences the divide, push and emit phases of one conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire rdc_pkg::t_status  i_status,
    output rdc_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);

    rdc_pkg::t_state               r_state;
    rdc_pkg::t_state               n_state;
    logic [rdc_pkg::CYC_WIDTH-1:0] r_cycle;
    logic [rdc_pkg::CYC_WIDTH-1:0] n_cycle;
    logic                          div_done;

    assign div_done = (r_cycle == rdc_pkg::CYC_WIDTH'(rdc_pkg::DIV_CYCLES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = rdc_pkg::S_DIVIDE;
                end
            end
            rdc_pkg::S_DIVIDE: begin
                if (div_done) begin
                    n_state = rdc_pkg::S_PUSH;
                end
            end
            rdc_pkg::S_PUSH: begin
                if (i_status.quo_zero) begin
                    n_state = rdc_pkg::S_EMIT;
                end else begin
                    n_state = rdc_pkg::S_DIVIDE;
                end
            end
            rdc_pkg::S_EMIT: begin
                if (i_status.last_digit) begin
                    n_state = rdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        n_cycle = '0;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            rdc_pkg::S_DIVIDE: begin
                o_cmd.step = 1'b1;
                n_cycle    = r_cycle + rdc_pkg::CYC_WIDTH'(1);
            end
            rdc_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
            end
            rdc_pkg::S_EMIT: begin
                o_cmd.pop = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
            r_cycle <= '0;
        end else begin
            r_state <= n_state;
            r_cycle <= n_cycle;
        end
    end

    assign o_busy = (r_state != rdc_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: design/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Writes an unsigned value as ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// A word is accepted when start is high while busy is low. The value is
// divided by the radix once per digit, and the digits are then sent out most
// significant first, one per cycle on o_strobe, with o_last marking the final
// (least significant) digit. The receiver cannot stall the output, so each
// digit must be taken in the cycle in which o_strobe is high. Each division
// resolves eight quotient bits per clock, and each digit is then pushed onto
// the digit stack; the divider is the unit that sets the rate. Busy falls in
// the same cycle in which the last digit is shown, so the next word may be
// accepted then. A zero value yields the single character '0', leading zeros
// are never produced, and radix values below two or above thirty-six are
// treated as two and thirty-six.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic [rdc_pkg::VALUE_WIDTH-1:0]   i_value,
    input  wire logic [rdc_pkg::RADIX_WIDTH-1:0]   i_radix,
    output logic                                   busy,
    output logic                                   o_strobe,
    output logic [rdc_pkg::CHAR_WIDTH-1:0]         o_digit_char,
    output logic                                   o_last
);

    // Command and status bundles between the sequencer and the datapath.
    rdc_pkg::t_cmd    cmd;
    rdc_pkg::t_status status;

    // The controller walks idle, divide, push and emit phases.
    rdc_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds the divider, the digit stack and the output word.
    rdc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: design/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              o_strobe,
    input  wire logic [rdc_pkg::CHAR_WIDTH-1:0]    o_digit_char,
    input  wire logic                              o_last
);

    // An accepted word always starts a conversion.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Only the final digit may appear after the block has gone idle.
    a_mid_digit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final digit shown while idle");

    // The final digit is shown exactly as the block returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("busy still high with the final digit");

    a_fall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_last)
        else $error("busy fell without a final digit");

    // Every character is a decimal digit or an upper-case letter.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            (o_digit_char >= rdc_pkg::ASCII_ZERO && o_digit_char <= rdc_pkg::ASCII_NINE) ||
            (o_digit_char >= rdc_pkg::ASCII_UPPER_A &&
             o_digit_char <= rdc_pkg::ASCII_UPPER_Z))
        else $error("digit character out of range");

endmodule

bind radix_digit_converter_top rdc_checker u_rdc_checker (.*);

`default_nettype wire
